// File: design/swdr_pkg.sv
// Shared types and constants for the sliding window deviation ranker.
package swdr_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int REC_W      = 64;
  localparam int WSUM_W     = 16 + SLOT_W;
  localparam int INFL_W     = 22;
  localparam int ABS_W      = 21;
  localparam int ACC_W      = ABS_W + SLOT_W;
  localparam int FRAC_W     = 17;

  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] REG_WLEN  = 2'd0;
  localparam logic [1:0] REG_TOP   = 2'd1;
  localparam logic [1:0] REG_THR   = 2'd2;
  localparam logic [1:0] REG_EN    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SUM,
    ST_PASS,
    ST_PASS_END,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: design/swdr_div.sv
// Bit-serial divider: floor(a * 2^16 / d) for a <= d, one quotient bit per cycle.
module swdr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [swdr_pkg::ACC_W-1:0]  num,
  input  logic [swdr_pkg::ACC_W-1:0]  den,
  output logic [swdr_pkg::FRAC_W-1:0] quot,
  output swdr_pkg::div_stat_t         stat
);
  import swdr_pkg::*;

  localparam int STEP_W = $clog2(FRAC_W + 1);

  logic [ACC_W:0]    rem;
  logic [ACC_W-1:0]  dreg;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;
  logic              ge;
  logic [ACC_W:0]    rem_sub;

  assign ge      = rem >= {1'b0, dreg};
  assign rem_sub = ge ? (rem - {1'b0, dreg}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(FRAC_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num};
      dreg <= den;
      quot <= '0;
    end else if (busy) begin
      quot <= {quot[FRAC_W-2:0], ge};
      rem  <= {rem_sub[ACC_W-1:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: design/sliding_window_deviation_ranker.sv
// Top level of the sliding window deviation ranker: record ring, ranking sequencer, output.
// Record item: its status follows a summing pass, k ranking passes over the n held records
//   (k = min(top_count, n)) and a division, none when the dominance check is off, no division
//   when the top sum is 0. Throughput: one item at a time; a query emits its ranked entries
//   one by one, each after a ranking pass and a division. The rate is set by the single read
//   port of the record memory, one entry per cycle per pass, and by the bit-serial divider.
// Reset: synchronous; window empty, sequence 0, registers at 16, 16, 65536, 0. No clearing pass.
module sliding_window_deviation_ranker (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic [15:0]                   token_id,
  input  logic signed [15:0]            weight,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          kind,
  output logic                          dominant,
  output logic [16:0]                   fraction,
  output logic [15:0]                   entry_token,
  output logic signed [15:0]            entry_weight,
  output logic signed [21:0]            influence,
  output logic [16:0]                   cum_fraction,
  output logic [31:0]                   sequence_res,
  output logic [4:0]                    held_records,
  output logic                          last,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import swdr_pkg::*;

  // ---------------------------------------------------------------- registers
  logic [CNT_W-1:0]  wlen;
  logic [4:0]        top_count;
  logic [FRAC_W-1:0] thr;
  logic              dom_en;
  logic              cfg_wr;
  logic [4:0]        wlen_raw;
  logic [CNT_W-1:0]  wlen_next;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign wlen_raw = pwdata[4:0];

  always_comb begin
    if (wlen_raw == 5'd0) wlen_next = CNT_W'(1);
    else if (32'(wlen_raw) > MAX_WINDOW) wlen_next = CNT_W'(MAX_WINDOW);
    else wlen_next = wlen_raw[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen      <= CNT_W'(MAX_WINDOW);
      top_count <= 5'd16;
      thr       <= 17'h10000;
      dom_en    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WLEN: wlen      <= wlen_next;
        REG_TOP:  top_count <= pwdata[4:0];
        REG_THR:  thr       <= pwdata[16:0];
        REG_EN:   dom_en    <= pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WLEN: prdata = 32'(wlen);
      REG_TOP:  prdata = 32'(top_count);
      REG_THR:  prdata = 32'(thr);
      REG_EN:   prdata = 32'(dom_en);
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- record memory
  // Written only in idle on an accepted record item, read only while ranking, so a
  // read never meets a write to the same entry.
  logic [REC_W-1:0]  rec_mem [MAX_WINDOW];
  logic [REC_W-1:0]  rd_data;
  logic [SLOT_W-1:0] rd_addr;
  logic              mem_wr;

  logic [SLOT_W-1:0] wpos;
  logic [CNT_W-1:0]  held;
  logic [31:0]       next_seq;

  always_ff @(posedge clk) begin
    if (mem_wr) rec_mem[wpos] <= {token_id, weight, next_seq};
    rd_data <= rec_mem[rd_addr];
  end

  // ---------------------------------------------------------------- sequencer state
  state_t            state, state_next;
  logic              accept;
  logic [1:0]        mode_q;
  logic [15:0]       tok_q;
  logic [15:0]       wt_q;
  logic [31:0]       seq_q;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  rank;
  logic [SLOT_W-1:0] start_slot;
  logic [CNT_W-1:0]  i_rd;
  logic              rd_pend;
  logic [SLOT_W-1:0] i_pd;
  logic signed [WSUM_W-1:0] wsum;
  logic [ACC_W-1:0]  total;
  logic [ACC_W-1:0]  top_sum;
  logic [ACC_W-1:0]  running;
  logic [ABS_W-1:0]  top_abs;
  logic [MAX_WINDOW-1:0] used;
  logic              best_found;
  logic [ABS_W-1:0]  best_abs;
  logic [SLOT_W-1:0] best_idx;
  logic signed [INFL_W-1:0] best_infl;
  logic [REC_W-1:0]  best_rec;
  logic              no_frac;

  // control strobes
  logic scan_init;
  logic scan_last;
  logic out_free;
  logic check_dom;
  logic div_start;
  logic div_zero;
  logic [CNT_W-1:0] k_new;
  logic [ACC_W-1:0] div_num;
  logic [ACC_W-1:0] div_den;
  logic [FRAC_W-1:0] div_q;
  div_stat_t div_st;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign mem_wr   = accept && (mode == MODE_RECORD);

  // ranked entries for this item, from the count as updated by the accepted item
  assign k_new = (top_count < 5'(held)) ? top_count[CNT_W-1:0] : held;

  // dominance check is only worth running with more than one record and a live threshold
  assign check_dom = dom_en && !thr[FRAC_W-1] && (held > CNT_W'(1)) && (k_new != '0);
  assign scan_last = rd_pend && ({1'b0, i_pd} == held - 1'b1);

  // per-entry influence of the record coming out of memory
  logic signed [15:0]       rd_w;
  logic signed [INFL_W-1:0] rd_infl;
  logic [ABS_W-1:0]         rd_abs;
  logic [CNT_W:0]           slot_sum;

  assign rd_w    = rd_data[47:32];
  assign rd_infl = INFL_W'($signed({1'b0, held}) * rd_w) - INFL_W'(wsum);
  assign rd_abs  = rd_infl[INFL_W-1] ? ABS_W'(-rd_infl) : ABS_W'(rd_infl);

  // ring position of the i_rd-th oldest record
  assign slot_sum = {1'b0, start_slot} + {1'b0, i_rd};
  assign rd_addr  = (slot_sum >= {1'b0, wlen}) ? SLOT_W'(slot_sum - {1'b0, wlen})
                                              : SLOT_W'(slot_sum);

  assign div_zero = (div_den == '0);
  assign div_num  = (mode_q == MODE_RECORD) ? ACC_W'(top_abs) : running;
  assign div_den  = (mode_q == MODE_RECORD) ? top_sum : total;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (mode == MODE_RECORD || mode == MODE_QUERY)) state_next = ST_START;
      end
      ST_START: begin
        if (mode_q == MODE_RECORD) state_next = check_dom ? ST_SUM : ST_EMIT;
        else state_next = (k_new == '0) ? ST_IDLE : ST_SUM;
      end
      ST_SUM:      if (scan_last) state_next = ST_PASS;
      ST_PASS:     if (scan_last) state_next = ST_PASS_END;
      ST_PASS_END: begin
        if (mode_q == MODE_RECORD && rank + 1'b1 != k) state_next = ST_PASS;
        else state_next = ST_DIV_GO;
      end
      ST_DIV_GO:   state_next = div_zero ? ST_EMIT : ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_st.done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (mode_q == MODE_RECORD || rank == k) state_next = ST_IDLE;
          else state_next = ST_PASS;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    scan_init = (state_next != state) && (state_next == ST_SUM || state_next == ST_PASS);
    div_start = (state == ST_DIV_GO) && !div_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos     <= '0;
      held     <= '0;
      next_seq <= '0;
    end else if (cfg_wr && paddr[3:2] == REG_WLEN) begin
      wpos <= '0;
      held <= '0;
    end else if (accept) begin
      case (mode)
        MODE_RECORD: begin
          next_seq <= next_seq + 1'b1;
          wpos     <= ({1'b0, wpos} + 1'b1 == wlen) ? '0 : wpos + 1'b1;
          if (held < wlen) held <= held + 1'b1;
        end
        MODE_CLEAR: begin
          wpos     <= '0;
          held     <= '0;
          next_seq <= '0;
        end
        default: ;
      endcase
    end
  end

  // ranking datapath
  logic [CNT_W:0] oldest;
  assign oldest = {1'b0, wpos} + {1'b0, wlen} - {1'b0, held};

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode;
      tok_q  <= token_id;
      wt_q   <= weight;
      seq_q  <= next_seq;
    end

    if (state == ST_START) begin
      k          <= k_new;
      start_slot <= (oldest >= {1'b0, wlen}) ? SLOT_W'(oldest - {1'b0, wlen})
                                            : SLOT_W'(oldest);
      rank       <= '0;
      used       <= '0;
      wsum       <= '0;
      total      <= '0;
      top_sum    <= '0;
      running    <= '0;
      no_frac    <= !check_dom;
    end

    // memory scan: one read issued per cycle, its data handled in the next cycle
    if (scan_init) begin
      i_rd       <= '0;
      rd_pend    <= 1'b0;
      best_found <= 1'b0;
    end else if (state == ST_SUM || state == ST_PASS) begin
      rd_pend <= (i_rd < held);
      i_pd    <= SLOT_W'(i_rd);
      if (i_rd < held) i_rd <= i_rd + 1'b1;
    end

    if (state == ST_SUM && rd_pend) wsum <= wsum + WSUM_W'(rd_w);

    if (state == ST_PASS && rd_pend) begin
      if (rank == '0) total <= total + ACC_W'(rd_abs);
      // strict compare keeps the older record on equal magnitude
      if (!used[i_pd] && (!best_found || rd_abs > best_abs)) begin
        best_found <= 1'b1;
        best_abs   <= rd_abs;
        best_idx   <= i_pd;
        best_infl  <= rd_infl;
        best_rec   <= rd_data;
      end
    end

    if (state == ST_PASS_END) begin
      used[best_idx] <= 1'b1;
      rank           <= rank + 1'b1;
      top_sum        <= top_sum + ACC_W'(best_abs);
      running        <= running + ACC_W'(best_abs);
      if (rank == '0) top_abs <= best_abs;
    end
  end

  swdr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_q),
    .stat  (div_st)
  );

  // ---------------------------------------------------------------- output register
  logic [FRAC_W-1:0] frac_val;
  assign frac_val = (no_frac || div_zero) ? '0 : div_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      held_records <= held;
      if (mode_q == MODE_RECORD) begin
        kind         <= 1'b0;
        dominant     <= !no_frac && !div_zero && (frac_val >= thr);
        fraction     <= frac_val;
        entry_token  <= tok_q;
        entry_weight <= wt_q;
        influence    <= '0;
        cum_fraction <= '0;
        sequence_res <= seq_q;
        last         <= 1'b0;
      end else begin
        kind         <= 1'b1;
        dominant     <= 1'b0;
        fraction     <= '0;
        entry_token  <= best_rec[63:48];
        entry_weight <= best_rec[47:32];
        influence    <= best_infl;
        cum_fraction <= div_zero ? '0 : div_q;
        sequence_res <= best_rec[31:0];
        last         <= (rank == k);
      end
    end
  end

  // ---------------------------------------------------------------- checks
  a_held_bound: assert property (@(posedge clk) disable iff (rst) held <= wlen)
    else $error("held count exceeds window length");

  a_wpos_bound: assert property (@(posedge clk) disable iff (rst) {1'b0, wpos} < wlen)
    else $error("write position outside window");

  a_div_idle: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_st.busy)
    else $error("divider restarted while busy");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free) |=> out_valid)
    else $error("emit did not load output register");

endmodule
